FILE: rtl/pst_pkg.sv
// pst_pkg: shared types and codes for the pareto skyline table
// used by the channel interfaces, the compare unit and the top level
`default_nettype none

package pst_pkg;

  localparam int CMD_W   = 2;
  localparam int ITEMS_W = 64;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 3;
  localparam int CNT_W   = 7;

  // request commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO      = 3'd1;
  localparam logic [ST_W-1:0] ST_DOMINATED = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_DUMP      = 3'd4;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;
  localparam logic [ST_W-1:0] ST_CLEARED   = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ITEMS_W-1:0] itemset;
    logic [VAL_W-1:0]   utility;
    logic [VAL_W-1:0]   frequency;
  } in_req_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [CNT_W-1:0]   removed_count;
    logic [CNT_W-1:0]   live_count;
    logic [ITEMS_W-1:0] entry_itemset;
    logic [VAL_W-1:0]   entry_utility;
    logic [VAL_W-1:0]   entry_frequency;
    logic               last;
  } out_rsp_t;

  // dominance flags between candidate and one stored slot
  typedef struct packed {
    logic slot_beats;
    logic cand_beats;
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: rtl/pst_in_if.sv
// pst_in_if: request channel, valid/ready with the request payload
// depends on pst_pkg
`default_nettype none

interface pst_in_if;
  logic             valid;
  logic             ready;
  pst_pkg::in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/pst_out_if.sv
// pst_out_if: result channel, valid/ready with the result payload
// depends on pst_pkg
`default_nettype none

interface pst_out_if;
  logic              valid;
  logic              ready;
  pst_pkg::out_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/pst_ram.sv
// pst_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module pst_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pst_cmp.sv
// pst_cmp: shared dominance compare unit, candidate against one slot
// depends on pst_pkg
`default_nettype none

module pst_cmp (
  input  wire logic [pst_pkg::VAL_W-1:0] cand_freq,
  input  wire logic [pst_pkg::VAL_W-1:0] cand_util,
  input  wire logic [pst_pkg::VAL_W-1:0] slot_freq,
  input  wire logic [pst_pkg::VAL_W-1:0] slot_util,
  output pst_pkg::cmp_res_t              res
);
  import pst_pkg::*;

  logic f_ge, f_gt, u_ge, u_gt, f_le, f_lt, u_le, u_lt;

  always_comb begin
    f_ge = slot_freq >= cand_freq;
    f_gt = slot_freq >  cand_freq;
    u_ge = slot_util >= cand_util;
    u_gt = slot_util >  cand_util;
    f_le = slot_freq <= cand_freq;
    f_lt = slot_freq <  cand_freq;
    u_le = slot_util <= cand_util;
    u_lt = slot_util <  cand_util;
    res.slot_beats = (f_ge && u_gt) || (f_gt && u_ge);
    res.cand_beats = (f_le && u_lt) || (f_lt && u_le);
  end

endmodule

`default_nettype wire

FILE: rtl/pareto_skyline_table.sv
// pareto_skyline_table: two objective skyline table over (frequency, utility)
// depends on pst_pkg, pst_in_if, pst_out_if, pst_ram, pst_cmp
//
//   channel  | dir | handshake          | carries
//   ---------+-----+--------------------+----------------------------------------
//   in_req   | in  | valid/ready        | command, itemset, utility, frequency
//   out_rsp  | out | valid/ready        | status, counts, dumped entry, last
//
// insert: the result follows a scan with one ram read per slot through the
//   shared compare unit; zero utility, clear and empty dump skip the scan
// dump: free slots below the last entry are skipped in S_DUMP_RD, each stored
//   entry is read there and loaded in S_DUMP_LD, which waits on output stalls
// reset clears slot valid bits and the live count at once, no clearing pass
// in_req.ready is high only when the sequencer is idle; a held result does not
//   block a new request, which waits for the output register before it reports
`default_nettype none

module pareto_skyline_table #(
  parameter int CAPACITY   = 64,
  parameter int ITEM_COUNT = 64
) (
  input wire logic   clk,
  input wire logic   rst_n,
  pst_in_if.sink     in_req,
  pst_out_if.source  out_rsp
);
  import pst_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int RAM_W = ITEM_COUNT + 2 * VAL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RESP,
    S_DUMP_RD,
    S_DUMP_LD
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         idx_r;        // slot index issued to the ram
  logic                  pend_r;       // read data in flight for pend_idx_r
  logic [AW-1:0]         pend_idx_r;
  logic [CAPACITY-1:0]   valid_r;
  logic [CAPACITY-1:0]   kill_r;       // slots the candidate dominates
  logic                  dom_r;        // candidate dominated by some slot
  logic                  found_r;      // free slot found
  logic [AW-1:0]         free_r;
  logic [CW-1:0]         rm_cnt_r;
  logic [CW-1:0]         count_r;
  logic [ITEM_COUNT-1:0] cand_items_r;
  logic [VAL_W-1:0]      cand_util_r;
  logic [VAL_W-1:0]      cand_freq_r;
  logic [ST_W-1:0]       resp_st_r;
  logic                  last_r;
  logic                  out_valid_r;
  out_rsp_t              out_data_r;

  logic                  out_free;
  logic                  out_load;     // a result enters the output register
  logic                  ram_rd_en;
  logic                  ram_wr_en;
  logic [RAM_W-1:0]      ram_wr_data;
  logic [RAM_W-1:0]      ram_rd_data;
  logic [ITEM_COUNT-1:0] slot_items;
  logic [VAL_W-1:0]      slot_util;
  logic [VAL_W-1:0]      slot_freq;
  logic                  more_after;   // any valid slot above idx_r
  logic [CW-1:0]         ins_count;
  cmp_res_t              cmp;

  // ram word: {itemset, utility, frequency}
  always_comb begin
    slot_items  = ram_rd_data[RAM_W-1:2*VAL_W];
    slot_util   = ram_rd_data[2*VAL_W-1:VAL_W];
    slot_freq   = ram_rd_data[VAL_W-1:0];
    ram_wr_data = {cand_items_r, cand_util_r, cand_freq_r};
  end

  always_comb begin
    out_free   = !out_valid_r || out_rsp.ready;
    out_load   = out_free && ((state_r == S_DECIDE) || (state_r == S_RESP) ||
                              (state_r == S_DUMP_LD));
    ram_rd_en  = ((state_r == S_SCAN) && (idx_r != CW'(CAPACITY))) ||
                 ((state_r == S_DUMP_RD) && (idx_r != CW'(CAPACITY)) &&
                  valid_r[idx_r[AW-1:0]]);
    ram_wr_en  = (state_r == S_DECIDE) && out_free && !dom_r && found_r;
    more_after = |(valid_r >> (idx_r + CW'(1)));
    // live count after a non dominated insert
    ins_count  = count_r - rm_cnt_r + CW'(found_r);
  end

  pst_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (free_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // one compare unit, reused for every slot of the scan
  pst_cmp u_cmp (
    .cand_freq (cand_freq_r),
    .cand_util (cand_util_r),
    .slot_freq (slot_freq),
    .slot_util (slot_util),
    .res       (cmp)
  );

  assign in_req.ready  = (state_r == S_IDLE);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      kill_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      dom_r       <= 1'b0;
      found_r     <= 1'b0;
      rm_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result loads, otherwise a taken result empties the register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.valid && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            cand_items_r <= in_req.data.itemset[ITEM_COUNT-1:0];
            cand_util_r  <= in_req.data.utility;
            cand_freq_r  <= in_req.data.frequency;
            unique case (in_req.data.command)
              CMD_INSERT: begin
                if (in_req.data.utility == '0) begin
                  resp_st_r <= ST_ZERO;
                  state_r   <= S_RESP;
                end else begin
                  idx_r    <= '0;
                  pend_r   <= 1'b0;
                  dom_r    <= 1'b0;
                  found_r  <= 1'b0;
                  kill_r   <= '0;
                  rm_cnt_r <= '0;
                  state_r  <= S_SCAN;
                end
              end
              CMD_DUMP: begin
                if (valid_r == '0) begin
                  resp_st_r <= ST_EMPTY;
                  state_r   <= S_RESP;
                end else begin
                  idx_r   <= '0;
                  state_r <= S_DUMP_RD;
                end
              end
              CMD_CLEAR: begin
                valid_r   <= '0;
                count_r   <= '0;
                resp_st_r <= ST_CLEARED;
                state_r   <= S_RESP;
              end
              default: begin
                // unused command: no state change, no result
              end
            endcase
          end
        end

        S_SCAN: begin
          // read issue one slot ahead of the compare
          pend_r     <= (idx_r != CW'(CAPACITY));
          pend_idx_r <= idx_r[AW-1:0];
          if (idx_r != CW'(CAPACITY)) begin
            idx_r <= idx_r + CW'(1);
          end
          if (pend_r) begin
            if (valid_r[pend_idx_r] && cmp.slot_beats) begin
              dom_r <= 1'b1;
            end
            if (valid_r[pend_idx_r] && cmp.cand_beats) begin
              kill_r[pend_idx_r] <= 1'b1;
              rm_cnt_r           <= rm_cnt_r + CW'(1);
            end
            // lowest slot that is free once dominated entries are gone
            if (!found_r && (!valid_r[pend_idx_r] || cmp.cand_beats)) begin
              found_r <= 1'b1;
              free_r  <= pend_idx_r;
            end
          end else if (idx_r == CW'(CAPACITY)) begin
            state_r <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (out_free) begin
            out_data_r.entry_itemset   <= '0;
            out_data_r.entry_utility   <= '0;
            out_data_r.entry_frequency <= '0;
            out_data_r.last            <= 1'b1;
            if (dom_r) begin
              out_data_r.status        <= ST_DOMINATED;
              out_data_r.removed_count <= '0;
              out_data_r.live_count    <= CNT_W'(count_r);
            end else begin
              // drop dominated slots and claim the free one in one update
              valid_r <= (valid_r & ~kill_r) | (CAPACITY'(found_r) << free_r);
              if (found_r) begin
                out_data_r.status <= ST_INSERTED;
              end else begin
                out_data_r.status <= ST_FULL;
              end
              count_r                  <= ins_count;
              out_data_r.removed_count <= CNT_W'(rm_cnt_r);
              out_data_r.live_count    <= CNT_W'(ins_count);
            end
            state_r <= S_IDLE;
          end
        end

        S_RESP: begin
          if (out_free) begin
            out_data_r.status          <= resp_st_r;
            out_data_r.removed_count   <= '0;
            out_data_r.live_count      <= CNT_W'(count_r);
            out_data_r.entry_itemset   <= '0;
            out_data_r.entry_utility   <= '0;
            out_data_r.entry_frequency <= '0;
            out_data_r.last            <= 1'b1;
            state_r                    <= S_IDLE;
          end
        end

        S_DUMP_RD: begin
          // skip free slots, one per cycle
          if (idx_r == CW'(CAPACITY)) begin
            state_r <= S_IDLE;
          end else if (valid_r[idx_r[AW-1:0]]) begin
            last_r  <= !more_after;
            state_r <= S_DUMP_LD;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end

        S_DUMP_LD: begin
          // ram output holds until the next read is issued
          if (out_free) begin
            out_data_r.status          <= ST_DUMP;
            out_data_r.removed_count   <= '0;
            out_data_r.live_count      <= CNT_W'(count_r);
            out_data_r.entry_itemset   <= ITEMS_W'(slot_items);
            out_data_r.entry_utility   <= slot_util;
            out_data_r.entry_frequency <= slot_freq;
            out_data_r.last            <= last_r;
            if (last_r) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + CW'(1);
              state_r <= S_DUMP_RD;
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // live count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("live count differs from valid slot count");

  // a committed insert leaves its slot valid
  a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |=> valid_r[$past(free_r)])
    else $error("inserted slot not valid");

  // the table is a skyline, so a dominated candidate can dominate nothing
  a_dom_no_kill: assert property (@(posedge clk) disable iff (!rst_n)
    dom_r |-> (kill_r == '0))
    else $error("dominated candidate marked slots for removal");

endmodule

`default_nettype wire
